@@ sv/nmrr_pkg.sv @@
package nmrr_pkg;

  // transfer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_NIB_START = 4'd1,
    PH_ACK_LOW   = 4'd2,
    PH_ACK_HIGH  = 4'd3,
    PH_TERM_LOW  = 4'd4,
    PH_TERM_HIGH = 4'd5
  } nmrr_phase_t;

  // end reasons reported in outcome
  localparam logic [2:0] OC_NONE       = 3'd0;
  localparam logic [2:0] OC_PERROR     = 3'd1;
  localparam logic [2:0] OC_NO_DATA    = 3'd2;
  localparam logic [2:0] OC_ACK_HIGH   = 3'd3;
  localparam logic [2:0] OC_TOTAL_TIME = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_LENGTH_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_WAIT_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_TOTAL_TIMEOUT = 2'd2;

  localparam logic [15:0] LENGTH_LIMIT_RST  = 16'd2047;
  localparam logic [31:0] WAIT_TIMEOUT_RST  = 32'd1000;
  localparam logic [31:0] TOTAL_TIMEOUT_RST = 32'd500;

  // status register bits
  localparam int unsigned ST_BUSY   = 7;
  localparam int unsigned ST_ACK    = 6;
  localparam int unsigned ST_PERROR = 5;

  typedef struct packed {
    logic       start_req;
    logic [7:0] status;
  } nmrr_in_t;

  typedef struct packed {
    logic        autofeed_bit;
    logic        select_in_bit;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        byte_stored;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  outcome;
    logic [15:0] byte_count;
  } nmrr_out_t;

  typedef struct packed {
    logic [15:0] length_limit;
    logic [31:0] wait_timeout_ticks;
    logic [31:0] total_timeout_ticks;
  } nmrr_cfg_t;

  typedef struct packed {
    nmrr_phase_t phase;
    logic [31:0] wait_cnt;
    logic [31:0] elapsed;
    logic [3:0]  low_nib;
    logic        nib_odd;
    logic [3:0]  cur_nib;
    logic [15:0] rcv_cnt;
    logic [2:0]  end_reason;
    logic        autofeed;
    logic        select_in;
  } nmrr_state_t;

endpackage

@@ sv/nmrr_step.sv @@
module nmrr_step import nmrr_pkg::*; (
  input  nmrr_cfg_t   cfg,
  input  nmrr_state_t cur,
  input  nmrr_in_t    beat,
  output nmrr_state_t nxt,
  output nmrr_out_t   res
);

  logic [31:0] wait_inc;
  logic        wait_miss;
  logic        active;
  logic        done;
  logic        valid;
  logic        stored;
  logic [7:0]  data;
  logic        ack;
  logic        busy;

  assign ack  = beat.status[ST_ACK];
  assign busy = beat.status[ST_BUSY];

  // saturating wait count and its timeout check
  assign wait_inc  = (cur.wait_cnt != '1) ? cur.wait_cnt + 32'd1 : cur.wait_cnt;
  assign wait_miss = (wait_inc >= cfg.wait_timeout_ticks);

  // one tick of the handshake sequencer
  always_comb begin
    nxt    = cur;
    active = 1'b1;
    done   = 1'b0;
    valid  = 1'b0;
    stored = 1'b0;
    data   = 8'd0;
    unique case (cur.phase)
      PH_NIB_START: begin
        if (cur.elapsed < cfg.total_timeout_ticks) begin
          nxt.autofeed = 1'b1;
          nxt.wait_cnt = '0;
          nxt.phase    = PH_ACK_LOW;
        end else begin
          nxt.end_reason = OC_TOTAL_TIME;
          nxt.autofeed   = 1'b0;
          nxt.select_in  = 1'b1;
          nxt.wait_cnt   = '0;
          nxt.phase      = PH_TERM_LOW;
        end
      end
      PH_ACK_LOW: begin
        if (!ack) begin
          nxt.cur_nib  = {~busy, beat.status[5:3]};
          nxt.autofeed = 1'b0;
          nxt.wait_cnt = '0;
          nxt.phase    = PH_ACK_HIGH;
        end else if (wait_miss) begin
          nxt.end_reason = OC_NO_DATA;
          nxt.autofeed   = 1'b0;
          nxt.select_in  = 1'b1;
          nxt.wait_cnt   = '0;
          nxt.phase      = PH_TERM_LOW;
        end else begin
          nxt.wait_cnt = wait_inc;
        end
      end
      PH_ACK_HIGH: begin
        if (ack) begin
          if (cur.nib_odd) begin
            data        = {cur.cur_nib, cur.low_nib};
            valid       = 1'b1;
            stored      = (cur.rcv_cnt < cfg.length_limit);
            nxt.rcv_cnt = (cur.rcv_cnt != '1) ? cur.rcv_cnt + 16'd1 : cur.rcv_cnt;
            nxt.nib_odd = 1'b0;
            if (beat.status[ST_PERROR]) begin
              nxt.end_reason = OC_PERROR;
              nxt.autofeed   = 1'b0;
              nxt.select_in  = 1'b1;
              nxt.wait_cnt   = '0;
              nxt.phase      = PH_TERM_LOW;
            end else begin
              nxt.phase = PH_NIB_START;
            end
          end else begin
            nxt.low_nib = cur.cur_nib;
            nxt.nib_odd = 1'b1;
            nxt.phase   = PH_NIB_START;
          end
        end else if (wait_miss) begin
          nxt.end_reason = OC_ACK_HIGH;
          nxt.autofeed   = 1'b0;
          nxt.select_in  = 1'b1;
          nxt.wait_cnt   = '0;
          nxt.phase      = PH_TERM_LOW;
        end else begin
          nxt.wait_cnt = wait_inc;
        end
      end
      PH_TERM_LOW: begin
        if (!busy) begin
          nxt.autofeed = 1'b1;
          nxt.wait_cnt = '0;
          nxt.phase    = PH_TERM_HIGH;
        end else begin
          nxt.wait_cnt = wait_inc;
          done         = wait_miss;
        end
      end
      PH_TERM_HIGH: begin
        if (busy) begin
          nxt.autofeed  = 1'b0;
          nxt.select_in = 1'b1;
          done          = 1'b1;
        end else begin
          nxt.wait_cnt = wait_inc;
          if (wait_miss) begin
            nxt.autofeed  = 1'b0;
            nxt.select_in = 1'b1;
            done          = 1'b1;
          end
        end
      end
      default: begin
        active    = 1'b0;
        nxt.phase = PH_IDLE;
        if (beat.start_req) begin
          nxt.wait_cnt   = '0;
          nxt.elapsed    = '0;
          nxt.low_nib    = '0;
          nxt.nib_odd    = 1'b0;
          nxt.cur_nib    = '0;
          nxt.rcv_cnt    = '0;
          nxt.end_reason = OC_NONE;
          nxt.phase      = PH_NIB_START;
        end
      end
    endcase

    // elapsed ticks count every active tick
    if (active && cur.elapsed != '1) begin
      nxt.elapsed = cur.elapsed + 32'd1;
    end
    if (done) begin
      nxt.phase = PH_IDLE;
    end
  end

  // result fields
  always_comb begin
    res.autofeed_bit  = nxt.autofeed;
    res.select_in_bit = nxt.select_in;
    res.data_byte     = data;
    res.byte_valid    = valid;
    res.byte_stored   = stored;
    res.busy_res      = (nxt.phase != PH_IDLE);
    res.done_res      = done;
    res.outcome       = done ? cur.end_reason : OC_NONE;
    res.byte_count    = nxt.rcv_cnt;
  end

endmodule

@@ sv/nibble_mode_reverse_reader_unit.sv @@
// host side of a nibble-mode reverse read on a parallel port
// each input beat is one tick: a start pulse and the sampled status byte
// each input beat gives exactly one output beat with the control bits to
// drive (autofeed, select-in), any completed byte, busy/done and outcome
// input channel: in_valid/in_stall carrying in_data; output channel:
// out_valid/out_stall carrying out_data; the block stalls its source only
// when both its input register and its output register are full and
// out_stall is high
// each accepted beat is held in the input register, and its result is then
// registered in the result register and shown on out_data; one beat per
// cycle is sustained while out_stall stays low, since the sequencer update
// between the input register and the result register is combinational
// when out_stall is held, the result holds, one more beat is buffered in
// the input register and then in_stall rises
// configuration: cfg_we with cfg_index 0 length limit, 1 handshake wait
// timeout, 2 overall timeout; write only while the block is idle
// reset (rst_n low at a clock edge) empties both registers, puts the
// sequencer in idle with all counters zero and loads the register defaults
module nibble_mode_reverse_reader_unit import nmrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  nmrr_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output nmrr_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  nmrr_cfg_t   cfg_r;
  nmrr_state_t state_r;
  nmrr_state_t state_nxt;
  nmrr_in_t    in_data_r;
  logic        in_valid_r;
  logic        out_valid_r;
  nmrr_out_t   out_data_r;
  nmrr_out_t   res_nxt;
  logic        advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.length_limit        <= LENGTH_LIMIT_RST;
      cfg_r.wait_timeout_ticks  <= WAIT_TIMEOUT_RST;
      cfg_r.total_timeout_ticks <= TOTAL_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LENGTH_LIMIT:  cfg_r.length_limit        <= cfg_wdata[15:0];
        CFG_WAIT_TIMEOUT:  cfg_r.wait_timeout_ticks  <= cfg_wdata;
        CFG_TOTAL_TIMEOUT: cfg_r.total_timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
  end

  nmrr_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .beat (in_data_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, end_reason: OC_NONE, default: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ bench/nibble_reader_checker.sv @@
`timescale 1ns / 1ps

module nibble_reader_checker import nmrr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  nmrr_in_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  nmrr_out_t          out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int unsigned        fail_count,
  output int unsigned        exp_count,
  output nmrr_phase_t        model_phase,
  output int unsigned        ticks_checked,
  output int unsigned        bytes_seen,
  output int unsigned        reads_done
);

  // register copies
  logic [15:0] lim_bytes;
  logic [31:0] hs_limit;
  logic [31:0] run_limit;

  // sequencer copy
  nmrr_phase_t seq_phase;
  logic [31:0] hs_wait;
  logic [31:0] run_ticks;
  logic [3:0]  first_nib;
  logic        second_half;
  logic [3:0]  latched_nib;
  logic [15:0] byte_total;
  logic [2:0]  stop_reason;
  logic        feed_lvl;
  logic        selin_lvl;

  nmrr_out_t   due_results[$];
  int unsigned fails = 0;
  int unsigned n_ticks = 0;
  int unsigned n_bytes = 0;
  int unsigned n_done = 0;

  function automatic void reset_model();
    lim_bytes   = LENGTH_LIMIT_RST;
    hs_limit    = WAIT_TIMEOUT_RST;
    run_limit   = TOTAL_TIMEOUT_RST;
    seq_phase   = PH_IDLE;
    hs_wait     = '0;
    run_ticks   = '0;
    first_nib   = '0;
    second_half = 1'b0;
    latched_nib = '0;
    byte_total  = '0;
    stop_reason = OC_NONE;
    feed_lvl    = 1'b0;
    selin_lvl   = 1'b0;
  endfunction

  // one missed tick of a handshake wait, true once the wait has run out
  function automatic bit handshake_miss();
    if (hs_wait != 32'hFFFF_FFFF) hs_wait++;
    return hs_wait >= hs_limit;
  endfunction

  function automatic void start_term(logic [2:0] why);
    stop_reason = why;
    feed_lvl    = 1'b0;
    selin_lvl   = 1'b1;
    hs_wait     = '0;
    seq_phase   = PH_TERM_LOW;
  endfunction

  // advance the sequencer copy by one tick and form the port outputs
  function automatic nmrr_out_t predict_tick(nmrr_in_t beat);
    nmrr_out_t  res;
    logic [7:0] st;
    logic [7:0] data;
    logic       valid;
    logic       stored;
    logic       done;
    logic       active;
    st     = beat.status;
    data   = '0;
    valid  = 1'b0;
    stored = 1'b0;
    done   = 1'b0;
    active = 1'b1;
    case (seq_phase)
      PH_NIB_START: begin
        if (run_ticks < run_limit) begin
          feed_lvl  = 1'b1;
          hs_wait   = '0;
          seq_phase = PH_ACK_LOW;
        end else begin
          start_term(OC_TOTAL_TIME);
        end
      end
      PH_ACK_LOW: begin
        if (!st[ST_ACK]) begin
          latched_nib = {~st[ST_BUSY], st[5:3]};
          feed_lvl    = 1'b0;
          hs_wait     = '0;
          seq_phase   = PH_ACK_HIGH;
        end else if (handshake_miss()) begin
          start_term(OC_NO_DATA);
        end
      end
      PH_ACK_HIGH: begin
        if (st[ST_ACK]) begin
          if (second_half) begin
            data   = {latched_nib, first_nib};
            valid  = 1'b1;
            stored = byte_total < lim_bytes;
            if (byte_total != 16'hFFFF) byte_total++;
            second_half = 1'b0;
            if (st[ST_PERROR]) start_term(OC_PERROR);
            else seq_phase = PH_NIB_START;
          end else begin
            first_nib   = latched_nib;
            second_half = 1'b1;
            seq_phase   = PH_NIB_START;
          end
        end else if (handshake_miss()) begin
          start_term(OC_ACK_HIGH);
        end
      end
      PH_TERM_LOW: begin
        if (!st[ST_BUSY]) begin
          feed_lvl  = 1'b1;
          hs_wait   = '0;
          seq_phase = PH_TERM_HIGH;
        end else if (handshake_miss()) begin
          done = 1'b1;
        end
      end
      PH_TERM_HIGH: begin
        if (st[ST_BUSY] || handshake_miss()) begin
          feed_lvl  = 1'b0;
          selin_lvl = 1'b1;
          done      = 1'b1;
        end
      end
      default: begin
        // idle: a start pulse opens a new read
        active    = 1'b0;
        seq_phase = PH_IDLE;
        if (beat.start_req) begin
          hs_wait     = '0;
          run_ticks   = '0;
          first_nib   = '0;
          second_half = 1'b0;
          latched_nib = '0;
          byte_total  = '0;
          stop_reason = OC_NONE;
          seq_phase   = PH_NIB_START;
        end
      end
    endcase
    if (active && run_ticks != 32'hFFFF_FFFF) run_ticks++;
    if (done) seq_phase = PH_IDLE;
    res.autofeed_bit  = feed_lvl;
    res.select_in_bit = selin_lvl;
    res.data_byte     = data;
    res.byte_valid    = valid;
    res.byte_stored   = stored;
    res.busy_res      = seq_phase != PH_IDLE;
    res.done_res      = done;
    res.outcome       = done ? stop_reason : OC_NONE;
    res.byte_count    = byte_total;
    return res;
  endfunction

  function automatic void check_field(string fld, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      if (fails <= 10)
        $display("%0t: %s mismatch, expected %0h got %0h", $time, fld, want_v, got_v);
    end
  endfunction

  // follow both channels and the register port
  always @(posedge clk) begin : track
    nmrr_out_t want;
    if (!rst_n) begin
      reset_model();
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LENGTH_LIMIT:  lim_bytes = cfg_wdata[15:0];
          CFG_WAIT_TIMEOUT:  hs_limit  = cfg_wdata;
          CFG_TOTAL_TIMEOUT: run_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(predict_tick(in_data));
        n_ticks++;
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: result beat with nothing expected", $time);
        end else begin
          want = due_results.pop_front();
          check_field("autofeed_bit", 32'(want.autofeed_bit),
                      32'(out_data.autofeed_bit));
          check_field("select_in_bit", 32'(want.select_in_bit),
                      32'(out_data.select_in_bit));
          check_field("data_byte", 32'(want.data_byte), 32'(out_data.data_byte));
          check_field("byte_valid", 32'(want.byte_valid), 32'(out_data.byte_valid));
          check_field("byte_stored", 32'(want.byte_stored), 32'(out_data.byte_stored));
          check_field("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
          check_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
          check_field("outcome", 32'(want.outcome), 32'(out_data.outcome));
          check_field("byte_count", 32'(want.byte_count), 32'(out_data.byte_count));
          if (want.byte_valid) n_bytes++;
          if (want.done_res) n_done++;
        end
      end
    end
    fail_count    <= fails;
    exp_count     <= due_results.size();
    model_phase   <= seq_phase;
    ticks_checked <= n_ticks;
    bytes_seen    <= n_bytes;
    reads_done    <= n_done;
  end

endmodule

@@ bench/nibble_mode_reverse_reader_unit_tb.sv @@
`timescale 1ns / 1ps

module nibble_mode_reverse_reader_unit_tb;
  import nmrr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  nmrr_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  nmrr_out_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned exp_count;
  nmrr_phase_t model_phase;
  int unsigned ticks_checked;
  int unsigned bytes_seen;
  int unsigned reads_done;
  int unsigned settings_run = 0;

  nibble_mode_reverse_reader_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nibble_reader_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .exp_count     (exp_count),
    .model_phase   (model_phase),
    .ticks_checked (ticks_checked),
    .bytes_seen    (bytes_seen),
    .reads_done    (reads_done)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("[nibble_mode_reverse_reader_unit] ERROR");
    $finish;
  end

  // result side: random stalls per beat, calm stretches, one long hold-off
  initial begin : result_side
    int gap;
    int got_beats;
    int calm_left;
    logic calm;
    bit held;
    out_stall = 1'b0;
    got_beats = 0;
    calm_left = 0;
    calm = 1'b0;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(20, 60);
      end
      calm_left--;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (!held && got_beats >= 400) begin
        held = 1'b1;
        gap = 60;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      got_beats++;
    end
  end

  // present one tick and hold it until taken
  task automatic send_beat(input logic go, input logic [7:0] st, input int gap);
    nmrr_in_t beat;
    beat.start_req = go;
    beat.status    = st;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  // status that moves the sequencer out of its current phase quickly
  function automatic logic [7:0] finishing_status(nmrr_phase_t ph);
    logic [7:0] s;
    s = '0;
    case (ph)
      PH_ACK_LOW, PH_TERM_LOW: ;
      PH_ACK_HIGH: begin
        s[ST_ACK]    = 1'b1;
        s[ST_PERROR] = 1'b1;
      end
      PH_TERM_HIGH: s[ST_BUSY] = 1'b1;
      default: s[ST_ACK] = 1'b1;
    endcase
    return s;
  endfunction

  // walk any open read to its end, then let every result drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model_phase != PH_IDLE) begin
      send_beat(1'b0, finishing_status(model_phase), 0);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (exp_count != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] lim, input logic [31:0] hs,
                              input logic [31:0] total);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LENGTH_LIMIT;
    cfg_wdata <= {16'd0, lim};
    @(posedge clk);
    cfg_index <= CFG_WAIT_TIMEOUT;
    cfg_wdata <= hs;
    @(posedge clk);
    cfg_index <= CFG_TOTAL_TIMEOUT;
    cfg_wdata <= total;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  // peripheral-like traffic: nAck toggles in runs, occasional long holds,
  // random data and PError, start pulses and some pure noise
  task automatic run_random(input int n, input bit pause_mid);
    int         i;
    int         run_left;
    int         calm_left;
    logic       calm;
    logic       ack_lvl;
    logic [7:0] st;
    run_left  = 0;
    calm_left = 0;
    calm      = 1'b0;
    ack_lvl   = 1'b1;
    for (i = 0; i < n; i++) begin
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(20, 60);
      end
      calm_left--;
      if (run_left == 0) begin
        ack_lvl  = ~ack_lvl;
        run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 14)
                                                 : $urandom_range(1, 3);
      end
      run_left--;
      st = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) != 0) begin
        st[ST_ACK]    = ack_lvl;
        st[ST_PERROR] = ($urandom_range(0, 9) == 0);
      end
      send_beat($urandom_range(0, 5) == 0, st, calm ? 0 : $urandom_range(0, 4));
      // sender waits for every outstanding result once
      if (pause_mid && i == n / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (exp_count != 0) @(posedge clk);
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    int ph;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_LENGTH_LIMIT;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed reads under reset defaults: bytes ff and 00, start while busy,
    // perror ending, full termination, then a byte d8 ended by perror
    send_beat(1'b1, 8'h40, 0);
    send_beat(1'b0, 8'h40, 0);
    send_beat(1'b0, 8'h38, 1);
    send_beat(1'b0, 8'h40, 0);
    send_beat(1'b1, 8'h40, 2);
    send_beat(1'b0, 8'h38, 0);
    send_beat(1'b0, 8'h40, 0);
    send_beat(1'b0, 8'h40, 3);
    send_beat(1'b0, 8'h80, 0);
    send_beat(1'b0, 8'hC0, 0);
    send_beat(1'b0, 8'h40, 4);
    send_beat(1'b0, 8'h87, 0);
    send_beat(1'b0, 8'h60, 0);
    send_beat(1'b0, 8'h00, 1);
    send_beat(1'b0, 8'h80, 0);
    send_beat(1'b1, 8'hFF, 0);
    send_beat(1'b0, 8'h40, 0);
    send_beat(1'b0, 8'h00, 2);
    send_beat(1'b0, 8'h40, 0);
    send_beat(1'b0, 8'h40, 0);
    send_beat(1'b0, 8'h28, 0);
    send_beat(1'b0, 8'hE0, 0);
    settle();

    // register settings, extremes first
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: program_regs(16'd0, 32'd1, 32'd1);
        1: program_regs(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: program_regs(16'd3, 32'd3, 32'd40);
        3: program_regs(16'($urandom_range(0, 12)), $urandom_range(1, 6),
                        $urandom_range(8, 200));
        default: program_regs(LENGTH_LIMIT_RST, 32'd2, 32'd120);
      endcase
      run_random(216, ph == 2);
      settle();
    end

    // drain and verdict
    in_valid <= 1'b0;
    while (exp_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d status ticks across %0d register settings plus defaults",
             ticks_checked, settings_run);
    $display("%0d bytes assembled, %0d reads taken through termination",
             bytes_seen, reads_done);
    if (fail_count == 0 && exp_count == 0)
      $display("[nibble_mode_reverse_reader_unit] OK");
    else
      $display("[nibble_mode_reverse_reader_unit] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/nmrr_pkg.sv
sv/nmrr_step.sv
sv/nibble_mode_reverse_reader_unit.sv
bench/nibble_reader_checker.sv
bench/nibble_mode_reverse_reader_unit_tb.sv
